// ===== rtl/line_line_closest_params_unit_assert.svh =====
// ----------------------------------------------------------------------------
// line_line_closest_params_unit assertion macros
// Short forms for clocked implication checks used by the unit.
// ----------------------------------------------------------------------------
`ifndef LINE_LINE_CLOSEST_PARAMS_UNIT_ASSERT_SVH
`define LINE_LINE_CLOSEST_PARAMS_UNIT_ASSERT_SVH

// same-cycle implication
`define LLCP_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define LLCP_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/llcp_pkg.sv =====
// ----------------------------------------------------------------------------
// llcp_pkg
// Widths and index tables for the line-line closest point unit.
// ----------------------------------------------------------------------------
`default_nettype none

package llcp_pkg;

   localparam int COORD_WIDTH  = 24;
   localparam int RESULT_WIDTH = 32;
   // fraction bits of the Q16.16 result
   localparam int FRAC_BITS    = 16;

   // operand pairs of a cross product: term k is a[XA[k]] * b[XB[k]],
   // component i is term 2i minus term 2i+1
   localparam int XA [6] = '{1, 2, 2, 0, 0, 1};
   localparam int XB [6] = '{2, 1, 0, 2, 1, 0};

endpackage

`default_nettype wire

// ===== rtl/line_line_closest_params_unit.sv =====
// ----------------------------------------------------------------------------
// line_line_closest_params_unit
// Closest point parameters s and t of two 3D lines, fixed point.
// ----------------------------------------------------------------------------
// One line pair is accepted every clock cycle and one result leaves every
// cycle while the result side does not stall. Seven stages form the
// offset, the two cross products, the squared length and the two triple
// products with exact wide arithmetic, then a restoring divider that
// resolves one quotient bit per stage (RESULT_WIDTH + 1 stages) and an
// output register. A stall on the result side freezes the whole pipeline.
// Parallel lines give s = t = 0 and not_parallel = 0; quotients are truncated
// toward zero and saturated.
`default_nettype none
`include "line_line_closest_params_unit_assert.svh"

module line_line_closest_params_unit #(
   parameter int COORD_WIDTH  = llcp_pkg::COORD_WIDTH,
   parameter int RESULT_WIDTH = llcp_pkg::RESULT_WIDTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [COORD_WIDTH-1:0]  req_first_point_x,
   input  logic signed [COORD_WIDTH-1:0]  req_first_point_y,
   input  logic signed [COORD_WIDTH-1:0]  req_first_point_z,
   input  logic signed [COORD_WIDTH-1:0]  req_first_dir_x,
   input  logic signed [COORD_WIDTH-1:0]  req_first_dir_y,
   input  logic signed [COORD_WIDTH-1:0]  req_first_dir_z,
   input  logic signed [COORD_WIDTH-1:0]  req_second_point_x,
   input  logic signed [COORD_WIDTH-1:0]  req_second_point_y,
   input  logic signed [COORD_WIDTH-1:0]  req_second_point_z,
   input  logic signed [COORD_WIDTH-1:0]  req_second_dir_x,
   input  logic signed [COORD_WIDTH-1:0]  req_second_dir_y,
   input  logic signed [COORD_WIDTH-1:0]  req_second_dir_z,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [RESULT_WIDTH-1:0] rsp_param_s,
   output logic signed [RESULT_WIDTH-1:0] rsp_param_t,
   output logic                           rsp_not_parallel
);

   localparam int CW   = COORD_WIDTH;
   localparam int RW   = RESULT_WIDTH;
   localparam int FB   = llcp_pkg::FRAC_BITS;
   localparam int DW   = CW + 1;          // offset
   localparam int PCW  = 2 * CW;          // direction products
   localparam int CRW  = 2 * CW + 1;      // cross product of directions
   localparam int PEW  = 2 * CW + 1;      // offset times direction
   localparam int EW   = 2 * CW + 2;      // cross product with offset
   localparam int H    = CW + 1;          // low half of a split operand
   localparam int PW   = 2 * CW + 4;      // partial products
   localparam int TW   = 4 * CW + 3;      // triple products and squares
   localparam int LW   = 4 * CW + 1;      // squared length, unsigned
   localparam int NW   = TW - 1 + FB;     // scaled numerator magnitude
   localparam int XW   = LW + RW + 1;     // divider remainder
   localparam int QW   = RW + 1;          // quotient with overflow bit
   localparam int NSTG = RW + 1;          // divider stages
   localparam int NV   = 7 + NSTG;        // stages carrying a valid bit
   localparam logic [RW-1:0] SAT_POS = {1'b0, {(RW-1){1'b1}}};
   localparam logic [RW-1:0] SAT_NEG = {1'b1, {(RW-1){1'b0}}};

   logic          pipe_en;
   logic [NV-1:0] pipe_valid_ff;
   logic          rsp_valid_ff;

   logic signed [CW-1:0] in_p0 [3];
   logic signed [CW-1:0] in_v0 [3];
   logic signed [CW-1:0] in_p1 [3];
   logic signed [CW-1:0] in_v1 [3];

   assign in_p0 = '{req_first_point_x, req_first_point_y, req_first_point_z};
   assign in_v0 = '{req_first_dir_x, req_first_dir_y, req_first_dir_z};
   assign in_p1 = '{req_second_point_x, req_second_point_y, req_second_point_z};
   assign in_v1 = '{req_second_dir_x, req_second_dir_y, req_second_dir_z};

   // the pipeline moves whenever the output register is free or being emptied
   assign pipe_en   = !rsp_valid_ff || rsp_ready;
   assign req_ready = pipe_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else if (pipe_en) begin
         pipe_valid_ff <= {pipe_valid_ff[NV-2:0], req_valid};
         rsp_valid_ff  <= pipe_valid_ff[NV-1];
      end
   end

   // stage a: offset and direction products
   logic signed [DW-1:0]  a_d_in  [3];
   logic signed [PCW-1:0] a_pc_in [6];
   logic signed [DW-1:0]  a_d_ff  [3];
   logic signed [PCW-1:0] a_pc_ff [6];
   logic signed [CW-1:0]  a_v0_ff [3];
   logic signed [CW-1:0]  a_v1_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         a_d_in[i] = DW'(in_p1[i]) - DW'(in_p0[i]);
      end
      for (int k = 0; k < 6; k++) begin
         a_pc_in[k] = in_v0[llcp_pkg::XA[k]] * in_v1[llcp_pkg::XB[k]];
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         a_d_ff  <= a_d_in;
         a_pc_ff <= a_pc_in;
         a_v0_ff <= in_v0;
         a_v1_ff <= in_v1;
      end
   end

   // stage b: c = v0 x v1, products for d x v1 (lane 0) and d x v0 (lane 1)
   logic signed [CRW-1:0] b_c_in  [3];
   logic signed [PEW-1:0] b_pe_in [2][6];
   logic signed [CRW-1:0] b_c_ff  [3];
   logic signed [PEW-1:0] b_pe_ff [2][6];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         b_c_in[i] = CRW'(a_pc_ff[2*i]) - CRW'(a_pc_ff[2*i+1]);
      end
      for (int k = 0; k < 6; k++) begin
         b_pe_in[0][k] = a_d_ff[llcp_pkg::XA[k]] * a_v1_ff[llcp_pkg::XB[k]];
         b_pe_in[1][k] = a_d_ff[llcp_pkg::XA[k]] * a_v0_ff[llcp_pkg::XB[k]];
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         b_c_ff  <= b_c_in;
         b_pe_ff <= b_pe_in;
      end
   end

   // stage c: e lanes, partial products of the squares of c
   logic signed [EW-1:0] c_e_in  [2][3];
   logic signed [PW-1:0] c_hh_in [3];
   logic signed [PW-1:0] c_hl_in [3];
   logic signed [PW-1:0] c_ll_in [3];
   logic signed [EW-1:0] c_e_ff  [2][3];
   logic signed [CRW-1:0] c_c_ff [3];
   logic signed [PW-1:0] c_hh_ff [3];
   logic signed [PW-1:0] c_hl_ff [3];
   logic signed [PW-1:0] c_ll_ff [3];

   always_comb begin
      logic signed [CRW-H-1:0] hi;
      logic signed [H:0]       lo;
      for (int l = 0; l < 2; l++) begin
         for (int i = 0; i < 3; i++) begin
            c_e_in[l][i] = EW'(b_pe_ff[l][2*i]) - EW'(b_pe_ff[l][2*i+1]);
         end
      end
      for (int i = 0; i < 3; i++) begin
         hi = $signed(b_c_ff[i][CRW-1:H]);
         lo = $signed({1'b0, b_c_ff[i][H-1:0]});
         c_hh_in[i] = hi * hi;
         c_hl_in[i] = hi * lo;
         c_ll_in[i] = lo * lo;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         c_e_ff  <= c_e_in;
         c_c_ff  <= b_c_ff;
         c_hh_ff <= c_hh_in;
         c_hl_ff <= c_hl_in;
         c_ll_ff <= c_ll_in;
      end
   end

   // stage d: squares of c, partial products of e times c
   logic signed [TW-1:0] d_sq_in [3];
   logic signed [PW-1:0] d_pp_in [2][3][4];
   logic signed [TW-1:0] d_sq_ff [3];
   logic signed [PW-1:0] d_pp_ff [2][3][4];

   always_comb begin
      logic signed [EW-H-1:0]  ehi;
      logic signed [H:0]       elo;
      logic signed [CRW-H-1:0] chi;
      logic signed [H:0]       clo;
      for (int i = 0; i < 3; i++) begin
         // cross term appears twice, hence one extra bit of shift
         d_sq_in[i] = (TW'(c_hh_ff[i]) <<< (2*H)) + (TW'(c_hl_ff[i]) <<< (H+1))
                    + TW'(c_ll_ff[i]);
      end
      for (int l = 0; l < 2; l++) begin
         for (int i = 0; i < 3; i++) begin
            ehi = $signed(c_e_ff[l][i][EW-1:H]);
            elo = $signed({1'b0, c_e_ff[l][i][H-1:0]});
            chi = $signed(c_c_ff[i][CRW-1:H]);
            clo = $signed({1'b0, c_c_ff[i][H-1:0]});
            d_pp_in[l][i][0] = ehi * chi;
            d_pp_in[l][i][1] = ehi * clo;
            d_pp_in[l][i][2] = elo * chi;
            d_pp_in[l][i][3] = elo * clo;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         d_sq_ff <= d_sq_in;
         d_pp_ff <= d_pp_in;
      end
   end

   // stage e: squared length, products e_i * c_i
   logic signed [TW-1:0] e_sum_in;
   logic signed [TW-1:0] e_prod_in [2][3];
   logic [LW-1:0]        e_len2_ff;
   logic signed [TW-1:0] e_prod_ff [2][3];

   always_comb begin
      e_sum_in = d_sq_ff[0] + d_sq_ff[1] + d_sq_ff[2];
      for (int l = 0; l < 2; l++) begin
         for (int i = 0; i < 3; i++) begin
            e_prod_in[l][i] = (TW'(d_pp_ff[l][i][0]) <<< (2*H))
                            + (TW'(d_pp_ff[l][i][1]) <<< H)
                            + (TW'(d_pp_ff[l][i][2]) <<< H)
                            + TW'(d_pp_ff[l][i][3]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         e_len2_ff <= e_sum_in[LW-1:0];
         e_prod_ff <= e_prod_in;
      end
   end

   // stage f: triple products
   logic signed [TW-1:0] f_det_in [2];
   logic signed [TW-1:0] f_det_ff [2];
   logic [LW-1:0]        f_len2_ff;

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         f_det_in[l] = e_prod_ff[l][0] + e_prod_ff[l][1] + e_prod_ff[l][2];
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         f_det_ff  <= f_det_in;
         f_len2_ff <= e_len2_ff;
      end
   end

   // stage g and divider: entry 0 holds the scaled magnitudes
   logic [XW-1:0] dv_r_ff   [NSTG][2];
   logic [LW-1:0] dv_d_ff   [NSTG];
   logic [QW-1:0] dv_q_ff   [NSTG+1][2];
   logic          dv_neg_ff [NSTG+1][2];
   logic          dv_nz_ff  [NSTG+1];

   logic [XW-1:0] g_r_in   [2];
   logic          g_neg_in [2];

   always_comb begin
      logic [TW-1:0] mag;
      logic [NW-1:0] num;
      for (int l = 0; l < 2; l++) begin
         g_neg_in[l] = f_det_ff[l][TW-1];
         mag = g_neg_in[l] ? (~f_det_ff[l] + TW'(1)) : f_det_ff[l];
         num = {mag[TW-2:0], {FB{1'b0}}};
         g_r_in[l] = XW'(num);
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         dv_r_ff[0]   <= g_r_in;
         dv_d_ff[0]   <= f_len2_ff;
         dv_q_ff[0]   <= '{QW'(0), QW'(0)};
         dv_neg_ff[0] <= g_neg_in;
         dv_nz_ff[0]  <= |f_len2_ff;
      end
   end

   // one quotient bit per stage, the first one flags overflow
   for (genvar j = 0; j < NSTG; j++) begin : g_div
      localparam int SH = RW - j;
      logic [XW-1:0] r_in [2];
      logic [QW-1:0] q_in [2];

      always_comb begin
         logic [XW-1:0] den_sh;
         logic [XW:0]   diff;
         den_sh = XW'(dv_d_ff[j]) << SH;
         for (int l = 0; l < 2; l++) begin
            diff = {1'b0, dv_r_ff[j][l]} - {1'b0, den_sh};
            if (!diff[XW]) begin
               r_in[l] = diff[XW-1:0];
               q_in[l] = {dv_q_ff[j][l][QW-2:0], 1'b1};
            end else begin
               r_in[l] = dv_r_ff[j][l];
               q_in[l] = {dv_q_ff[j][l][QW-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (pipe_en) begin
            dv_q_ff[j+1]   <= q_in;
            dv_neg_ff[j+1] <= dv_neg_ff[j];
            dv_nz_ff[j+1]  <= dv_nz_ff[j];
         end
      end

      if (j < NSTG - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (pipe_en) begin
               dv_r_ff[j+1] <= r_in;
               dv_d_ff[j+1] <= dv_d_ff[j];
            end
         end
      end
   end

   // sign, saturation and the parallel case
   logic [RW-1:0]   res_in [2];
   logic [RW-1:0]   rsp_s_ff;
   logic [RW-1:0]   rsp_t_ff;
   logic            rsp_np_ff;

   always_comb begin
      logic [QW-1:0] q;
      for (int l = 0; l < 2; l++) begin
         q = dv_q_ff[NSTG][l];
         if (!dv_nz_ff[NSTG]) begin
            res_in[l] = '0;
         end else if (!dv_neg_ff[NSTG][l]) begin
            res_in[l] = (q[RW] || q[RW-1]) ? SAT_POS : q[RW-1:0];
         end else if (q[RW] || (q[RW-1] && (|q[RW-2:0]))) begin
            res_in[l] = SAT_NEG;
         end else begin
            res_in[l] = (~q[RW-1:0]) + RW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         rsp_s_ff  <= res_in[0];
         rsp_t_ff  <= res_in[1];
         rsp_np_ff <= dv_nz_ff[NSTG];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_param_s      = $signed(rsp_s_ff);
   assign rsp_param_t      = $signed(rsp_t_ff);
   assign rsp_not_parallel = rsp_np_ff;

   `LLCP_ASSERT_IMP(a_parallel_zero, clock, reset, rsp_valid_ff && !rsp_np_ff, (rsp_s_ff == '0) && (rsp_t_ff == '0), "parallel lines gave nonzero parameters")
   `LLCP_ASSERT_NXT(a_stall_hold, clock, reset, !pipe_en, $stable(pipe_valid_ff) && rsp_valid_ff, "stalled pipeline lost or moved a transaction")
   `LLCP_ASSERT_NXT(a_accept_enters, clock, reset, req_valid && req_ready, pipe_valid_ff[0], "accepted transaction missing from first stage")

endmodule

`default_nettype wire
